FILE: rtl/rmq_pkg.sv
// Shared constants and types for the rotation matrix to quaternion unit.
package rmq_pkg;
  localparam int FracBitsDefault = 14;
  localparam int DataW = 16;

  typedef logic signed [DataW-1:0] sample_t;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  // one matrix in, row by row
  typedef struct packed {
    sample_t m00; sample_t m01; sample_t m02;
    sample_t m10; sample_t m11; sample_t m12;
    sample_t m20; sample_t m21; sample_t m22;
  } matrix_t;

  // one quaternion out, with the branch taken and the degenerate flag
  typedef struct packed {
    sample_t    qw; sample_t qx; sample_t qy; sample_t qz;
    logic [1:0] branch;
    logic       degenerate;
  } quat_t;

  function automatic logic signed [DataW-1:0] sat16(input logic signed [63:0] v);
    logic signed [DataW-1:0] r;
    if (v > 64'sd32767) r = 16'sh7fff;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = v[DataW-1:0];
    return r;
  endfunction
endpackage

FILE: rtl/rmq_stream_if.sv
// Valid/ready channel interface carrying a generic payload.
interface rmq_stream_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/rmq_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, with side-band payload.
module rmq_sqrt_pipe
  import rmq_pkg::*;
#(
  parameter int InW  = 64,
  parameter int SideW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [InW-1:0]       in_rad,
  input  logic [SideW-1:0]     in_side,
  output logic                 out_valid,
  output logic [InW/2-1:0]     out_root,
  output logic [SideW-1:0]     out_side
);
  localparam int Steps = InW / 2;

  logic [Steps:0]                 vld_r;
  logic [InW-1:0]                 rem_r  [Steps+1];
  logic [Steps-1:0]               root_r [Steps+1];
  logic [InW-1:0]                 val_r  [Steps+1];
  logic [SideW-1:0]               side_r [Steps+1];

  always_comb begin
    vld_r[0]  = in_valid;
    rem_r[0]  = '0;
    root_r[0] = '0;
    val_r[0]  = in_rad;
    side_r[0] = in_side;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [InW-1:0]   rem_nxt;
    logic [InW-1:0]   trial;
    logic [Steps-1:0] root_nxt;
    always_comb begin
      // bring down the next two radicand bits and try appending a one
      rem_nxt  = {rem_r[i][InW-3:0], val_r[i][InW-1-2*i -: 2]};
      trial    = {{(InW-Steps-2){1'b0}}, root_r[i], 2'b01};
      root_nxt = {root_r[i][Steps-2:0], 1'b0};
      if (rem_nxt >= trial) begin
        rem_nxt     = rem_nxt - trial;
        root_nxt[0] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
      if (en) begin
        rem_r[i+1]  <= rem_nxt;
        root_r[i+1] <= root_nxt;
        val_r[i+1]  <= val_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_valid = vld_r[Steps];
  assign out_root  = root_r[Steps];
  assign out_side  = side_r[Steps];
endmodule

FILE: rtl/rmq_div_pipe.sv
// Pipelined restoring unsigned divider, one quotient bit per stage, with side-band payload.
module rmq_div_pipe #(
  parameter int NumW  = 48,
  parameter int DenW  = 32,
  parameter int SideW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NumW-1:0]   in_num,
  input  logic [DenW-1:0]   in_den,
  input  logic [SideW-1:0]  in_side,
  output logic              out_valid,
  output logic [NumW-1:0]   out_quo,
  output logic [SideW-1:0]  out_side
);
  logic [NumW:0]         vld_r;
  logic [DenW:0]         rem_r  [NumW+1];
  logic [NumW-1:0]       num_r  [NumW+1];
  logic [DenW-1:0]       den_r  [NumW+1];
  logic [SideW-1:0]      side_r [NumW+1];

  always_comb begin
    vld_r[0]  = in_valid;
    rem_r[0]  = '0;
    num_r[0]  = in_num;
    den_r[0]  = in_den;
    side_r[0] = in_side;
  end

  for (genvar i = 0; i < NumW; i++) begin : g_step
    logic [DenW+1:0]  shifted;
    logic [DenW:0]    rem_nxt;
    logic [NumW-1:0]  num_nxt;
    always_comb begin
      shifted = {rem_r[i], num_r[i][NumW-1]};
      num_nxt = {num_r[i][NumW-2:0], 1'b0};
      if (shifted >= {2'b00, den_r[i]}) begin
        rem_nxt    = (DenW+1)'(shifted - {2'b00, den_r[i]});
        num_nxt[0] = 1'b1;
      end else begin
        rem_nxt = shifted[DenW:0];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
      if (en) begin
        rem_r[i+1]  <= rem_nxt;
        num_r[i+1]  <= num_nxt;
        den_r[i+1]  <= den_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_valid = vld_r[NumW];
  assign out_quo   = num_r[NumW];
  assign out_side  = side_r[NumW];
endmodule

FILE: rtl/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to quaternion: one matrix per cycle while the result side is not stalled.
// At the default FRAC_BITS of 14 the pipeline is one input stage, 17 square root stages,
// 31 divider stages (one per quotient bit) and the output register.
// Every stage advances together when the output register is empty or being taken, so a
// stall on the result side holds the whole pipeline and loses nothing.
module rotation_matrix_to_quaternion_unit
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic clk,
  input  logic rst_n,
  rmq_stream_if.sink   in_ch,
  rmq_stream_if.source out_ch
);
  // radicand: one plus up to three 16-bit entries, signed
  localparam int RadW  = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
  localparam int SqW   = 2 * ((RadW + FRAC_BITS + 1) / 2);
  localparam int RootW = SqW / 2;
  localparam int NumW  = DataW + 1 + FRAC_BITS;
  localparam int DenW  = RootW + 1;
  localparam int MagW  = DataW + 1;
  // side band: branch, degenerate, root, three numerator signs
  localparam int SideW = 2 + 1 + RootW + 3;

  logic en;
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: branch choice, radicand, numerators
  logic                    s1_vld_r;
  logic [1:0]              s1_br_r;
  logic signed [RadW-1:0]  s1_rad_r;
  logic signed [MagW-1:0]  s1_n_r [3];

  logic signed [RadW-1:0]  trace, one, rad_nxt;
  logic [1:0]              br_nxt;
  logic signed [MagW-1:0]  n_nxt [3];
  logic signed [RadW-1:0]  a00, a11, a22;
  logic signed [MagW-1:0]  b01, b02, b10, b12, b20, b21;

  always_comb begin
    a00 = RadW'(in_ch.data.m00);
    a11 = RadW'(in_ch.data.m11);
    a22 = RadW'(in_ch.data.m22);
    b01 = MagW'(in_ch.data.m01);
    b02 = MagW'(in_ch.data.m02);
    b10 = MagW'(in_ch.data.m10);
    b12 = MagW'(in_ch.data.m12);
    b20 = MagW'(in_ch.data.m20);
    b21 = MagW'(in_ch.data.m21);
    one   = RadW'(1 << FRAC_BITS);
    trace = a00 + a11 + a22;
    if (trace > 0) begin
      br_nxt = BR_TRACE; rad_nxt = one + trace;
      n_nxt[0] = b21 - b12; n_nxt[1] = b02 - b20; n_nxt[2] = b10 - b01;
    end else if (a00 > a11 && a00 > a22) begin
      br_nxt = BR_X; rad_nxt = one + a00 - a11 - a22;
      n_nxt[0] = b21 - b12; n_nxt[1] = b01 + b10; n_nxt[2] = b02 + b20;
    end else if (a11 > a22) begin
      br_nxt = BR_Y; rad_nxt = one + a11 - a00 - a22;
      n_nxt[0] = b02 - b20; n_nxt[1] = b01 + b10; n_nxt[2] = b12 + b21;
    end else begin
      br_nxt = BR_Z; rad_nxt = one + a22 - a00 - a11;
      n_nxt[0] = b10 - b01; n_nxt[1] = b02 + b20; n_nxt[2] = b12 + b21;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_ch.valid;
    end
    if (en) begin
      s1_br_r  <= br_nxt;
      s1_rad_r <= rad_nxt;
      s1_n_r   <= n_nxt;
    end
  end

  // square root, carrying numerators along
  localparam int SqSide = 2 + 1 + 3 * MagW;
  logic              s1_deg;
  logic [SqW-1:0]    sq_in;
  logic              sq_vld;
  logic [RootW-1:0]  sq_root;
  logic [SqSide-1:0] sq_side;

  assign s1_deg = (s1_rad_r <= 0);
  assign sq_in  = s1_deg ? '0 : SqW'({s1_rad_r[RadW-2:0], {FRAC_BITS{1'b0}}});

  rmq_sqrt_pipe #(.InW(SqW), .SideW(SqSide)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s1_vld_r), .in_rad(sq_in),
    .in_side({s1_br_r, s1_deg, s1_n_r[0], s1_n_r[1], s1_n_r[2]}),
    .out_valid(sq_vld), .out_root(sq_root), .out_side(sq_side)
  );

  logic [1:0]             sq_br;
  logic                   sq_deg;
  logic signed [MagW-1:0] sq_n [3];
  assign {sq_br, sq_deg, sq_n[0], sq_n[1], sq_n[2]} = sq_side;

  // three dividers in lockstep; lane 0 carries the side band
  logic [DenW-1:0]  den;
  logic [NumW-1:0]  dnum [3];
  logic [2:0]       dsgn;
  logic [NumW-1:0]  quo  [3];
  logic [SideW-1:0] dv_side;
  logic             dv_vld;
  logic [2:0]       dv_vld_unused;

  assign den = sq_deg ? DenW'(1) : {sq_root, 1'b0};

  for (genvar k = 0; k < 3; k++) begin : g_div
    logic [MagW-1:0]  mag;
    logic [SideW-1:0] sd;
    assign dsgn[k] = sq_n[k][MagW-1];
    assign mag     = dsgn[k] ? MagW'(-sq_n[k]) : MagW'(sq_n[k]);
    assign dnum[k] = {mag, {FRAC_BITS{1'b0}}};
    assign sd      = {sq_br, sq_deg, sq_root, dsgn};
    if (k == 0) begin : g_lead
      rmq_div_pipe #(.NumW(NumW), .DenW(DenW), .SideW(SideW)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(sq_vld), .in_num(dnum[k]), .in_den(den), .in_side(sd),
        .out_valid(dv_vld_unused[k]), .out_quo(quo[k]), .out_side(dv_side)
      );
      assign dv_vld = dv_vld_unused[k];
    end else begin : g_follow
      logic [SideW-1:0] unused_side;
      rmq_div_pipe #(.NumW(NumW), .DenW(DenW), .SideW(SideW)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(sq_vld), .in_num(dnum[k]), .in_den(den), .in_side(sd),
        .out_valid(dv_vld_unused[k]), .out_quo(quo[k]), .out_side(unused_side)
      );
    end
  end

  // output stage: place components, clamp, register
  logic [1:0]        o_br;
  logic              o_deg;
  logic [RootW-1:0]  o_root;
  logic [2:0]        o_sgn;
  assign {o_br, o_deg, o_root, o_sgn} = dv_side;

  logic signed [DataW-1:0] comp [3];
  logic signed [DataW-1:0] chosen;
  logic signed [DataW-1:0] q_nxt [4];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [NumW-1:0] qc;
      qc = (quo[k] > NumW'(65536)) ? NumW'(65536) : quo[k];
      comp[k] = sat16(o_sgn[k] ? -64'(qc) : 64'(qc));
    end
    chosen = sat16(64'(o_root >> 1));
    q_nxt[0] = '0; q_nxt[1] = '0; q_nxt[2] = '0; q_nxt[3] = '0;
    if (!o_deg) begin
      case (o_br)
        BR_TRACE: begin q_nxt[0] = chosen; q_nxt[1] = comp[0]; q_nxt[2] = comp[1];
                        q_nxt[3] = comp[2]; end
        BR_X: begin q_nxt[1] = chosen; q_nxt[0] = comp[0]; q_nxt[2] = comp[1];
                    q_nxt[3] = comp[2]; end
        BR_Y: begin q_nxt[2] = chosen; q_nxt[0] = comp[0]; q_nxt[1] = comp[1];
                    q_nxt[3] = comp[2]; end
        default: begin q_nxt[3] = chosen; q_nxt[0] = comp[0]; q_nxt[1] = comp[1];
                       q_nxt[2] = comp[2]; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
    if (en) begin
      out_ch.data.qw         <= q_nxt[0];
      out_ch.data.qx         <= q_nxt[1];
      out_ch.data.qy         <= q_nxt[2];
      out_ch.data.qz         <= q_nxt[3];
      out_ch.data.branch     <= o_br;
      out_ch.data.degenerate <= o_deg;
    end
  end

  assign out_ch.valid = out_valid_r;
endmodule
